// ===== hw/rtl/sid_pkg.sv =====
`default_nettype none

package sid_pkg;

  // operand width and iteration counter width
  localparam int DATA_WIDTH = 32;
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  // request payload
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] dividend;
    logic signed [DATA_WIDTH-1:0] divisor;
  } req_t;

  // response payload
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quotient;
    logic signed [DATA_WIDTH-1:0] remainder;
    logic                         divide_by_zero;
    logic                         overflow;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic last_step;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sid_datapath.sv =====
`default_nettype none

module sid_datapath (
  input  wire logic             clk,
  input  wire sid_pkg::req_t    req,
  input  wire sid_pkg::cmd_t    cmd,
  output sid_pkg::status_t      status,
  output sid_pkg::rsp_t         rsp
);

  localparam int W = sid_pkg::DATA_WIDTH;

  // working registers
  logic [W-1:0]              quo;
  logic [W-1:0]              rem;
  logic [W-1:0]              dsr;
  logic [sid_pkg::CNT_W-1:0] cnt;
  logic                      a_neg;
  logic                      q_neg;
  logic                      dz;
  logic                      ov;

  // operand magnitudes and special cases at load
  logic [W-1:0] a_mag_in;
  logic [W-1:0] b_mag_in;
  logic         dz_in;
  logic         ov_in;

  assign a_mag_in = req.dividend[W-1] ? (~req.dividend + {{(W-1){1'b0}}, 1'b1})
                                      : req.dividend;
  assign b_mag_in = req.divisor[W-1]  ? (~req.divisor + {{(W-1){1'b0}}, 1'b1})
                                      : req.divisor;
  assign dz_in    = (req.divisor == '0);
  assign ov_in    = (req.dividend == {1'b1, {(W-1){1'b0}}}) && (req.divisor == {W{1'b1}});

  // one restoring step
  logic [W:0] shifted;
  logic [W:0] diff;

  assign shifted = {rem, quo[W-1]};
  assign diff    = shifted - {1'b0, dsr};

  // sign fix-up of the final magnitudes
  logic [W-1:0] q_fix;
  logic [W-1:0] r_fix;

  assign q_fix = q_neg ? (~quo + {{(W-1){1'b0}}, 1'b1}) : quo;
  assign r_fix = a_neg ? (~rem + {{(W-1){1'b0}}, 1'b1}) : rem;

  assign status.last_step = (cnt == sid_pkg::CNT_W'(W - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quo   <= a_mag_in;
      rem   <= '0;
      dsr   <= b_mag_in;
      cnt   <= '0;
      a_neg <= req.dividend[W-1];
      q_neg <= req.dividend[W-1] ^ req.divisor[W-1];
      dz    <= dz_in;
      ov    <= ov_in;
    end else if (cmd.step) begin
      cnt <= cnt + sid_pkg::CNT_W'(1);
      if (!diff[W]) begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end
    end
    // output register
    if (cmd.finish) begin
      rsp.divide_by_zero <= dz;
      rsp.overflow       <= ov && !dz;
      if (dz) begin
        rsp.quotient  <= '0;
        rsp.remainder <= '0;
      end else if (ov) begin
        rsp.quotient  <= {1'b0, {(W-1){1'b1}}};
        rsp.remainder <= '0;
      end else begin
        rsp.quotient  <= q_fix;
        rsp.remainder <= r_fix;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sid_ctrl.sv =====
`default_nettype none

module sid_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  input  wire sid_pkg::status_t  status,
  output sid_pkg::cmd_t          cmd
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    FIX
  } state_t;

  state_t state;

  // command decode
  always_comb begin
    req_ready  = (state == IDLE);
    cmd.load   = (state == IDLE) && req_valid;
    cmd.step   = (state == RUN);
    cmd.finish = (state == FIX) && (!rsp_valid || rsp_ready);
  end

  // state and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (req_valid) begin
            state <= RUN;
          end
        end
        RUN: begin
          if (status.last_step) begin
            state <= FIX;
          end
        end
        FIX: begin
          if (cmd.finish) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/signed_integer_divider.sv =====
// Signed integer divider, quotient truncated toward zero.
//
// Request channel (req_valid/req_ready/req) carries dividend and divisor;
// response channel (rsp_valid/rsp_ready/rsp) carries quotient, remainder
// (sign of the dividend) and the divide_by_zero and overflow flags.
// A zero divisor gives zero results with divide_by_zero set; the most
// negative dividend over minus one gives the positive maximum, remainder
// zero and overflow set.
//
// Each request takes one restoring subtract-and-shift step per quotient bit
// in a single shared subtractor, then a sign fix-up into the output
// register. One item is worked on at a time, so a new request waits until
// the previous one is through the datapath. A new request is taken as soon
// as the previous one has moved to the output register, so a stalled
// receiver only holds up the pipe once the next result is ready.
// Reset (rst, synchronous) returns the controller to idle and drops
// rsp_valid; data registers are not cleared.
`default_nettype none

module signed_integer_divider (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire sid_pkg::req_t  req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output sid_pkg::rsp_t       rsp
);

  sid_pkg::cmd_t    cmd;
  sid_pkg::status_t status;

  // sequencing
  sid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // shift-subtract datapath and output register
  sid_datapath u_datapath (
    .clk    (clk),
    .req    (req),
    .cmd    (cmd),
    .status (status),
    .rsp    (rsp)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = sid_pkg::DATA_WIDTH;
  localparam logic [W-1:0] MOST_NEG  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS  = ~MOST_NEG;
  localparam logic [W-1:0] MINUS_ONE = '1;
  // request transfer to response valid with a receiver that keeps up, with margin
  localparam int LATENCY        = W + 2;
  localparam int RX_HOLD_CYCLES = 400;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_ready;
  sid_pkg::req_t  req = '0;
  logic           rsp_valid;
  logic           rsp_ready = 1'b0;
  sid_pkg::rsp_t  rsp;

  sid_pkg::rsp_t  expected_results[$];
  int    mismatch_count = 0;
  int    tx_idle_pct = 0;
  int    rx_idle_pct = 0;
  bit    rx_hold_request = 1'b0;

  signed_integer_divider dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // truncating division with sign fix-up and the two special cases
  function automatic sid_pkg::rsp_t divide_operands(sid_pkg::req_t op);
    sid_pkg::rsp_t res;
    logic [W-1:0] a_mag;
    logic [W-1:0] b_mag;
    logic [W-1:0] q_mag;
    logic [W-1:0] r_mag;
    logic       a_neg;
    logic       b_neg;
    res   = '0;
    a_neg = op.dividend[W-1];
    b_neg = op.divisor[W-1];
    if (op.divisor == '0) begin
      res.divide_by_zero = 1'b1;
    end else if (op.dividend == MOST_NEG && op.divisor == MINUS_ONE) begin
      res.quotient = MOST_POS;
      res.overflow = 1'b1;
    end else begin
      // unsigned magnitudes; the most negative value maps to 2^(W-1)
      a_mag = op.dividend;
      b_mag = op.divisor;
      if (a_neg) a_mag = ~a_mag + 1'b1;
      if (b_neg) b_mag = ~b_mag + 1'b1;
      q_mag = a_mag / b_mag;
      r_mag = a_mag % b_mag;
      if (a_neg != b_neg) q_mag = ~q_mag + 1'b1;
      if (a_neg) r_mag = ~r_mag + 1'b1;
      res.quotient  = q_mag;
      res.remainder = r_mag;
    end
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(80, 20);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [W-1:0] pick_corner();
    case ($urandom_range(4))
      0:       return '0;
      1:       return 1;
      2:       return MINUS_ONE;
      3:       return MOST_NEG;
      default: return MOST_POS;
    endcase
  endfunction

  // random magnitude spread over all sizes, random sign
  function automatic logic [W-1:0] pick_spread_word();
    logic [63:0] wide;
    logic [W-1:0] v;
    wide = {$urandom, $urandom};
    v = wide[W-1:0] >> $urandom_range(W-1);
    if ($urandom_range(1)) v = ~v + 1'b1;
    return v;
  endfunction

  function automatic sid_pkg::req_t make_operands();
    sid_pkg::req_t op;
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    op.dividend = wide[W-1:0];
    wide = {$urandom, $urandom};
    op.divisor = wide[W-1:0];
    case ($urandom_range(9))
      0, 1, 2: ;
      3: begin
        op.divisor = $urandom_range(255, 1);
        if ($urandom_range(1)) op.divisor = -op.divisor;
      end
      4: op.dividend = pick_corner();
      5: begin
        op.dividend = pick_corner();
        op.divisor  = pick_corner();
      end
      6: op.divisor = '0;
      7: begin
        if ($urandom_range(1)) op.dividend = MOST_NEG;
        op.divisor = $urandom_range(1) ? MINUS_ONE : W'($urandom_range(2, 1));
      end
      default: begin
        op.dividend = pick_spread_word();
        op.divisor  = pick_spread_word();
      end
    endcase
    return op;
  endfunction

  // offer one request and wait for its transfer; valid stays high on return
  task automatic send_operands(input logic [W-1:0] a, input logic [W-1:0] b);
    int            gap;
    sid_pkg::req_t op;
    op.dividend = a;
    op.divisor  = b;
    gap = pick_gap(tx_idle_pct);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= op;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    expected_results.push_back(divide_operands(op));
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_response(sid_pkg::rsp_t got);
    sid_pkg::rsp_t exp;
    if (expected_results.size() == 0) begin
      $error("unexpected response transfer: quotient %0d remainder %0d",
             got.quotient, got.remainder);
      mismatch_count++;
      return;
    end
    exp = expected_results.pop_front();
    if (got.quotient !== exp.quotient) begin
      $error("quotient: expected %0d, actual %0d", exp.quotient, got.quotient);
      mismatch_count++;
    end
    if (got.remainder !== exp.remainder) begin
      $error("remainder: expected %0d, actual %0d", exp.remainder, got.remainder);
      mismatch_count++;
    end
    if (got.divide_by_zero !== exp.divide_by_zero) begin
      $error("divide_by_zero: expected %0b, actual %0b",
             exp.divide_by_zero, got.divide_by_zero);
      mismatch_count++;
    end
    if (got.overflow !== exp.overflow) begin
      $error("overflow: expected %0b, actual %0b", exp.overflow, got.overflow);
      mismatch_count++;
    end
  endtask

  // response side: check each transfer, then pick next ready
  initial begin : response_monitor
    int idle_left;
    int hold_left;
    idle_left = 0;
    hold_left = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (rsp_valid && rsp_ready) check_response(rsp);
      if (rx_hold_request) begin
        hold_left       = RX_HOLD_CYCLES;
        rx_hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        rsp_ready <= 1'b0;
        hold_left--;
      end else if (idle_left > 0) begin
        rsp_ready <= 1'b0;
        idle_left--;
      end else begin
        rsp_ready <= 1'b1;
        idle_left = pick_gap(rx_idle_pct);
      end
      @(posedge clk);
    end
  end

  // sign combinations and exact division
  task automatic test_signs();
    send_operands(7, 2);
    send_operands(-7, 2);
    send_operands(7, -2);
    send_operands(-7, -2);
    send_operands(6, 3);
    send_operands(-6, 3);
    send_operands(-6, -3);
    send_operands(0, MINUS_ONE);
    send_operands(1, MINUS_ONE);
  endtask

  // zero divisor with several dividends
  task automatic test_divide_by_zero();
    send_operands(5, 0);
    send_operands(0, 0);
    send_operands(MOST_NEG, 0);
    send_operands(MOST_POS, 0);
  endtask

  // most negative over minus one saturates; over one and two it does not
  task automatic test_overflow();
    send_operands(MOST_NEG, MINUS_ONE);
    send_operands(MOST_NEG, 1);
    send_operands(MOST_NEG, 2);
  endtask

  // extremes of both operands
  task automatic test_extremes();
    send_operands(MOST_NEG, MOST_NEG);
    send_operands(MOST_POS, MOST_POS);
    send_operands(MOST_POS, MOST_NEG);
    send_operands(MOST_NEG, MOST_POS);
    send_operands(MOST_POS, 1);
    send_operands(MOST_POS, MINUS_ONE);
    send_operands(0, MOST_NEG);
    send_operands(MINUS_ONE, MOST_NEG);
  endtask

  // receiver holds off long while requests keep coming
  task automatic test_output_backpressure();
    tx_idle_pct     = 0;
    rx_hold_request = 1'b1;
    repeat (20) begin
      sid_pkg::req_t op;
      op = make_operands();
      send_operands(op.dividend, op.divisor);
    end
    drain_results();
  endtask

  // random traffic in phases of varying idling, with periodic drains
  task automatic test_random_traffic(int count);
    sid_pkg::req_t op;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(3))
          0:       tx_idle_pct = 0;
          1:       tx_idle_pct = 20;
          default: tx_idle_pct = 50;
        endcase
        case ($urandom_range(3))
          0:       rx_idle_pct = 0;
          1:       rx_idle_pct = 20;
          default: rx_idle_pct = 50;
        endcase
      end
      if (i % 300 == 299) drain_results();
      op = make_operands();
      send_operands(op.dividend, op.divisor);
    end
  endtask

  // reset, tests in turn, wrap-up
  initial begin : test_sequence
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    test_signs();
    test_divide_by_zero();
    test_overflow();
    test_extremes();
    drain_results();
    test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(200);
    test_random_traffic(1800);
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // timeout
  initial begin : watchdog
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sid_pkg.sv
hw/rtl/sid_datapath.sv
hw/rtl/sid_ctrl.sv
hw/rtl/signed_integer_divider.sv
dv/tb.sv
